@@ rtl/chm_pkg.sv @@
// ----------------------------------------------------------------------------
// chm_pkg
// Widths of the request and response fields, command and status codes.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int CMD_W  = 2;
  localparam int KEY_W  = 64;
  localparam int VAL_W  = 32;
  localparam int HASH_W = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 9;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_LOOKUP = 2'd2;
  localparam cmd_t CMD_CLEAR  = 2'd3;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_UPDATED   = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

endpackage

@@ rtl/chm_req_if.sv @@
// ----------------------------------------------------------------------------
// chm_req_if
// Request channel: command, key, value and precomputed hash.
// ----------------------------------------------------------------------------
interface chm_req_if;
  logic                       valid;
  logic                       ready;
  chm_pkg::cmd_t              command;
  logic [chm_pkg::KEY_W-1:0]  key;
  logic [chm_pkg::VAL_W-1:0]  value;
  logic [chm_pkg::HASH_W-1:0] hash;

  modport source (output valid, command, key, value, hash, input ready);
  modport sink (input valid, command, key, value, hash, output ready);
endinterface

@@ rtl/chm_rsp_if.sv @@
// ----------------------------------------------------------------------------
// chm_rsp_if
// Response channel: status, found flag, read value and occupancy.
// ----------------------------------------------------------------------------
interface chm_rsp_if;
  logic                      valid;
  logic                      ready;
  chm_pkg::status_t          status;
  logic                      found;
  logic [chm_pkg::VAL_W-1:0] read_value;
  logic [chm_pkg::OCC_W-1:0] occupancy;

  modport source (output valid, status, found, read_value, occupancy, input ready);
  modport sink (input valid, status, found, read_value, occupancy, output ready);
endinterface

@@ rtl/chained_hash_map_top.sv @@
// ----------------------------------------------------------------------------
// chained_hash_map_top
// Fixed-capacity key/value map with separate chaining in on-chip RAM.
// ----------------------------------------------------------------------------
// Requests enter on in_req (valid/ready), one response per request leaves on
// out_rsp (valid/ready). Commands: insert/update, remove, lookup, clear.
// The block works on one request at a time; in_req.ready is high only while
// the sequencer is idle. Every request but clear first forms the bucket
// index (reciprocal multiply in S_MOD, remainder in S_MOD2), reads the
// bucket's head and tail (S_HT_RD, S_HT_WT), then walks the chain; each
// step is a RAM read issued in S_WALK and a key compare in S_CMP, up to the
// match or the chain end. S_DECIDE then ends lookup, update, miss and
// table full, and unlinks the entry on remove; a new entry adds S_INS2 to
// link it in. A remove that frees a slot other than the last dense entry
// reads that entry (S_RD_LAST, S_LAST_WT), walks its chain to it and moves
// it into the freed slot (S_MOVE, S_MOVE2). Clear goes straight to S_DONE.
// The response sits in an output register; a stalled receiver holds it there
// and the next request is taken meanwhile, but a finished response waits
// until the previous one is taken.
// Reset empties all buckets at once through per-bucket valid flags and
// zeroes the entry count; no clearing pass runs. Clear does the same.
// ----------------------------------------------------------------------------
module chained_hash_map_top #(
  parameter int NUM_ENTRIES = 256,
  parameter int KEY_BITS    = 64,
  parameter int VALUE_BITS  = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  chm_req_if.sink  in_req,
  chm_rsp_if.source out_rsp
);

  localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int LNK_W = IDX_W + 1;
  localparam int ENT_W = KEY_BITS + VALUE_BITS + IDX_W;
  localparam logic [LNK_W-1:0] NIL = LNK_W'(NUM_ENTRIES);
  localparam int PROD_W = 2 * chm_pkg::HASH_W + 1;
  localparam int MOD_S  = chm_pkg::HASH_W + $clog2(NUM_ENTRIES);
  localparam logic [chm_pkg::HASH_W:0] MOD_M =
    (chm_pkg::HASH_W+1)'(((64'd1 << MOD_S) / 64'(NUM_ENTRIES)) + 64'd1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MOD     = 4'd1;
  localparam logic [3:0] S_HT_RD   = 4'd2;
  localparam logic [3:0] S_HT_WT   = 4'd3;
  localparam logic [3:0] S_WALK    = 4'd4;
  localparam logic [3:0] S_CMP     = 4'd5;
  localparam logic [3:0] S_DECIDE  = 4'd6;
  localparam logic [3:0] S_INS2    = 4'd7;
  localparam logic [3:0] S_RD_LAST = 4'd8;
  localparam logic [3:0] S_LAST_WT = 4'd9;
  localparam logic [3:0] S_MOVE    = 4'd10;
  localparam logic [3:0] S_MOVE2   = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;
  localparam logic [3:0] S_MOD2    = 4'd13;

  logic [3:0]                   state_r, state_nxt;
  chm_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [KEY_BITS-1:0]          key_r, key_nxt;
  logic [VALUE_BITS-1:0]        val_r, val_nxt;
  logic [chm_pkg::HASH_W-1:0]   hash_r, hash_nxt;
  logic [PROD_W-1:0]            prod_r, prod_nxt;
  logic [IDX_W-1:0]             b_r, b_nxt;
  logic [IDX_W-1:0]             lb_r, lb_nxt;
  logic                         phase_r, phase_nxt;
  logic [LNK_W-1:0]             h_r, h_nxt;
  logic [LNK_W-1:0]             t_r, t_nxt;
  logic [LNK_W-1:0]             cur_r, cur_nxt;
  logic [LNK_W-1:0]             prev_r, prev_nxt;
  logic [LNK_W-1:0]             steps_r, steps_nxt;
  logic                         hit_r, hit_nxt;
  logic                         at_r, at_nxt;
  logic [LNK_W-1:0]             slot_r, slot_nxt;
  logic [ENT_W-1:0]             slot_ent_r, slot_ent_nxt;
  logic [LNK_W-1:0]             slot_next_r, slot_next_nxt;
  logic [ENT_W-1:0]             last_ent_r, last_ent_nxt;
  logic [LNK_W-1:0]             last_next_r, last_next_nxt;
  logic [LNK_W-1:0]             count_r, count_nxt;
  logic [NUM_ENTRIES-1:0]       hv_r, hv_nxt;
  chm_pkg::status_t             status_r, status_nxt;
  logic [VALUE_BITS-1:0]        rd_r, rd_nxt;

  logic                         ov_r, ov_nxt;
  chm_pkg::status_t             o_status_r, o_status_nxt;
  logic                         o_found_r, o_found_nxt;
  logic [chm_pkg::VAL_W-1:0]    o_rd_r, o_rd_nxt;
  logic [chm_pkg::OCC_W-1:0]    o_occ_r, o_occ_nxt;

  logic                         ent_we;
  logic [IDX_W-1:0]             ent_wa, ent_ra;
  logic [ENT_W-1:0]             ent_wd, ent_rd;
  logic                         nxt_we;
  logic [IDX_W-1:0]             nxt_wa, nxt_ra;
  logic [LNK_W-1:0]             nxt_wd, nxt_rd;
  logic                         ht_we;
  logic [IDX_W-1:0]             ht_a;
  logic [2*LNK_W-1:0]           ht_wd, ht_rd;

  logic [chm_pkg::HASH_W-1:0]   quo, rem;
  logic [LNK_W-1:0]             last;
  logic [LNK_W-1:0]             nh, nt;
  logic                         in_acc;

  chm_ram #(.WIDTH(ENT_W), .DEPTH(NUM_ENTRIES)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd), .raddr(ent_ra), .rdata(ent_rd)
  );
  chm_ram #(.WIDTH(LNK_W), .DEPTH(NUM_ENTRIES)) u_nxt_ram (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(nxt_ra), .rdata(nxt_rd)
  );
  chm_ram #(.WIDTH(2*LNK_W), .DEPTH(NUM_ENTRIES)) u_ht_ram (
    .clk(clk), .we(ht_we), .waddr(ht_a), .wdata(ht_wd), .raddr(ht_a), .rdata(ht_rd)
  );

  assign in_req.ready       = (state_r == S_IDLE);
  assign in_acc             = in_req.valid && in_req.ready;
  assign out_rsp.valid      = ov_r;
  assign out_rsp.status     = o_status_r;
  assign out_rsp.found      = o_found_r;
  assign out_rsp.read_value = o_rd_r;
  assign out_rsp.occupancy  = o_occ_r;

  assign last = count_r - LNK_W'(1);
  assign ht_a = phase_r ? lb_r : b_r;

  assign quo = chm_pkg::HASH_W'(prod_r >> MOD_S);
  assign rem = hash_r - chm_pkg::HASH_W'(quo * chm_pkg::HASH_W'(NUM_ENTRIES));

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    hash_nxt      = hash_r;
    prod_nxt      = prod_r;
    b_nxt         = b_r;
    lb_nxt        = lb_r;
    phase_nxt     = phase_r;
    h_nxt         = h_r;
    t_nxt         = t_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    steps_nxt     = steps_r;
    hit_nxt       = hit_r;
    at_nxt        = at_r;
    slot_nxt      = slot_r;
    slot_ent_nxt  = slot_ent_r;
    slot_next_nxt = slot_next_r;
    last_ent_nxt  = last_ent_r;
    last_next_nxt = last_next_r;
    count_nxt     = count_r;
    hv_nxt        = hv_r;
    status_nxt    = status_r;
    rd_nxt        = rd_r;
    ov_nxt        = ov_r;
    o_status_nxt  = o_status_r;
    o_found_nxt   = o_found_r;
    o_rd_nxt      = o_rd_r;
    o_occ_nxt     = o_occ_r;

    ent_we = 1'b0;
    ent_wa = slot_r[IDX_W-1:0];
    ent_wd = last_ent_r;
    ent_ra = cur_r[IDX_W-1:0];
    nxt_we = 1'b0;
    nxt_wa = slot_r[IDX_W-1:0];
    nxt_wd = last_next_r;
    nxt_ra = cur_r[IDX_W-1:0];
    ht_we  = 1'b0;
    ht_wd  = {h_r, t_r};
    nh     = h_r;
    nt     = t_r;

    if (ov_r && out_rsp.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt     = in_req.command;
          key_nxt     = KEY_BITS'(in_req.key);
          val_nxt     = VALUE_BITS'(in_req.value);
          hash_nxt    = in_req.hash;
          b_nxt       = '0;
          phase_nxt   = 1'b0;
          rd_nxt      = '0;
          status_nxt  = chm_pkg::ST_DONE;
          hit_nxt     = 1'b0;
          if (in_req.command == chm_pkg::CMD_CLEAR) begin
            hv_nxt    = '0;
            count_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        prod_nxt  = PROD_W'(hash_r) * PROD_W'(MOD_M);
        state_nxt = S_MOD2;
      end
      S_MOD2: begin
        b_nxt     = IDX_W'(rem);
        state_nxt = S_HT_RD;
      end
      S_HT_RD: begin
        state_nxt = S_HT_WT;
      end
      S_HT_WT: begin
        h_nxt     = hv_r[ht_a] ? ht_rd[2*LNK_W-1:LNK_W] : NIL;
        t_nxt     = hv_r[ht_a] ? ht_rd[LNK_W-1:0] : NIL;
        cur_nxt   = hv_r[ht_a] ? ht_rd[2*LNK_W-1:LNK_W] : NIL;
        prev_nxt  = NIL;
        steps_nxt = '0;
        at_nxt    = 1'b0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (cur_r < count_r && steps_r < LNK_W'(NUM_ENTRIES)) begin
          state_nxt = S_CMP;
        end else begin
          state_nxt = phase_r ? S_MOVE : S_DECIDE;
        end
      end
      S_CMP: begin
        if (!phase_r && ent_rd[ENT_W-1 -: KEY_BITS] == key_r) begin
          hit_nxt       = 1'b1;
          slot_nxt      = cur_r;
          slot_ent_nxt  = ent_rd;
          slot_next_nxt = nxt_rd;
          state_nxt     = S_DECIDE;
        end else if (phase_r && cur_r == last) begin
          at_nxt    = 1'b1;
          state_nxt = S_MOVE;
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = nxt_rd;
          steps_nxt = steps_r + LNK_W'(1);
          state_nxt = S_WALK;
        end
      end
      S_DECIDE: begin
        state_nxt = S_DONE;
        if (cmd_r == chm_pkg::CMD_INSERT) begin
          if (hit_r) begin
            ent_we     = 1'b1;
            ent_wa     = slot_r[IDX_W-1:0];
            ent_wd     = {slot_ent_r[ENT_W-1 -: KEY_BITS], val_r, slot_ent_r[IDX_W-1:0]};
            status_nxt = chm_pkg::ST_UPDATED;
          end else if (count_r >= LNK_W'(NUM_ENTRIES)) begin
            status_nxt = chm_pkg::ST_FULL;
          end else begin
            ent_we    = 1'b1;
            ent_wa    = count_r[IDX_W-1:0];
            ent_wd    = {key_r, val_r, b_r};
            nxt_we    = 1'b1;
            nxt_wa    = count_r[IDX_W-1:0];
            nxt_wd    = NIL;
            state_nxt = S_INS2;
          end
        end else if (!hit_r) begin
          status_nxt = chm_pkg::ST_NOT_FOUND;
        end else if (cmd_r == chm_pkg::CMD_LOOKUP) begin
          rd_nxt = slot_ent_r[IDX_W +: VALUE_BITS];
        end else begin
          if (prev_r == NIL) begin
            nh = slot_next_r;
          end else begin
            nxt_we = 1'b1;
            nxt_wa = prev_r[IDX_W-1:0];
            nxt_wd = slot_next_r;
          end
          nt    = (t_r == slot_r) ? prev_r : t_r;
          ht_we = 1'b1;
          ht_wd = {nh, nt};
          if (slot_r != last) begin
            state_nxt = S_RD_LAST;
          end else begin
            count_nxt = last;
          end
        end
      end
      S_INS2: begin
        if (t_r < LNK_W'(NUM_ENTRIES) && h_r != NIL) begin
          nxt_we = 1'b1;
          nxt_wa = t_r[IDX_W-1:0];
          nxt_wd = count_r;
        end else begin
          nh = count_r;
        end
        ht_we        = 1'b1;
        ht_wd        = {nh, count_r};
        hv_nxt[b_r]  = 1'b1;
        count_nxt    = count_r + LNK_W'(1);
        state_nxt    = S_DONE;
      end
      S_RD_LAST: begin
        ent_ra    = last[IDX_W-1:0];
        nxt_ra    = last[IDX_W-1:0];
        state_nxt = S_LAST_WT;
      end
      S_LAST_WT: begin
        last_ent_nxt  = ent_rd;
        last_next_nxt = nxt_rd;
        lb_nxt        = ent_rd[IDX_W-1:0];
        phase_nxt     = 1'b1;
        state_nxt     = S_HT_RD;
      end
      S_MOVE: begin
        ent_we    = 1'b1;
        ent_wa    = slot_r[IDX_W-1:0];
        ent_wd    = last_ent_r;
        nxt_we    = 1'b1;
        nxt_wa    = slot_r[IDX_W-1:0];
        nxt_wd    = last_next_r;
        state_nxt = S_MOVE2;
      end
      S_MOVE2: begin
        if (at_r && prev_r != NIL) begin
          nxt_we = 1'b1;
          nxt_wa = prev_r[IDX_W-1:0];
          nxt_wd = slot_r;
        end
        nh           = (at_r && prev_r == NIL) ? slot_r : h_r;
        nt           = (t_r == last) ? slot_r : t_r;
        ht_we        = 1'b1;
        ht_wd        = {nh, nt};
        hv_nxt[lb_r] = 1'b1;
        count_nxt    = last;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_rsp.ready) begin
          ov_nxt       = 1'b1;
          o_status_nxt = status_r;
          o_found_nxt  = hit_r;
          o_rd_nxt     = chm_pkg::VAL_W'(rd_r);
          o_occ_nxt    = chm_pkg::OCC_W'(count_r);
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      hv_r    <= '0;
      ov_r    <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      hv_r    <= hv_nxt;
      ov_r    <= ov_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    hash_r      <= hash_nxt;
    prod_r      <= prod_nxt;
    b_r         <= b_nxt;
    lb_r        <= lb_nxt;
    h_r         <= h_nxt;
    t_r         <= t_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    steps_r     <= steps_nxt;
    hit_r       <= hit_nxt;
    at_r        <= at_nxt;
    slot_r      <= slot_nxt;
    slot_ent_r  <= slot_ent_nxt;
    slot_next_r <= slot_next_nxt;
    last_ent_r  <= last_ent_nxt;
    last_next_r <= last_next_nxt;
    status_r    <= status_nxt;
    rd_r        <= rd_nxt;
    o_status_r  <= o_status_nxt;
    o_found_r   <= o_found_nxt;
    o_rd_r      <= o_rd_nxt;
    o_occ_r     <= o_occ_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LNK_W'(NUM_ENTRIES))
    else $error("entry count above capacity");

  a_new_rsp_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!ov_r || out_rsp.ready) && state_r == S_DONE |=> ov_r && state_r == S_IDLE)
    else $error("response not issued from done state");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE && state_r != S_INS2 && state_r != S_DECIDE && state_r != S_MOVE2
    |=> $stable(count_r))
    else $error("entry count changed outside an update state");

  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> cur_r < count_r)
    else $error("chain walk read beyond live entries");

endmodule

@@ rtl/chm_ram.sv @@
// ----------------------------------------------------------------------------
// chm_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
